[rtl/bpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and widths for the pressure and temperature compensation block
// ----------------------------------------------------------------------------
package bpc_pkg;

    // datapath widths
    localparam int RAW_W  = 24;  // raw conversion words
    localparam int CAL_W  = 16;  // calibration words
    localparam int OUT_W  = 32;  // result words
    localparam int COMP_W = 40;  // offset and sensitivity, signed

    // factory calibration set
    typedef struct packed {
        logic [CAL_W-1:0] sens_ref;
        logic [CAL_W-1:0] off_ref;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] off_tempco;
        logic [CAL_W-1:0] temp_ref;
        logic [CAL_W-1:0] temp_tempco;
    } t_cal;

endpackage

[rtl/bpc_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_apb_regs
// apb register file holding the six calibration words
// ----------------------------------------------------------------------------
module bpc_apb_regs
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cal        o_cal
);

    localparam logic [2:0] REG_SENS_REF    = 3'd0;
    localparam logic [2:0] REG_OFF_REF     = 3'd1;
    localparam logic [2:0] REG_SENS_TEMPCO = 3'd2;
    localparam logic [2:0] REG_OFF_TEMPCO  = 3'd3;
    localparam logic [2:0] REG_TEMP_REF    = 3'd4;
    localparam logic [2:0] REG_TEMP_TEMPCO = 3'd5;

    t_cal       r_cal;
    t_cal       n_cal;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;

    always_comb begin
        n_cal = r_cal;
        if (w_wr) begin
            case (w_idx)
                REG_SENS_REF:    n_cal.sens_ref    = pwdata[CAL_W-1:0];
                REG_OFF_REF:     n_cal.off_ref     = pwdata[CAL_W-1:0];
                REG_SENS_TEMPCO: n_cal.sens_tempco = pwdata[CAL_W-1:0];
                REG_OFF_TEMPCO:  n_cal.off_tempco  = pwdata[CAL_W-1:0];
                REG_TEMP_REF:    n_cal.temp_ref    = pwdata[CAL_W-1:0];
                REG_TEMP_TEMPCO: n_cal.temp_tempco = pwdata[CAL_W-1:0];
                default:         n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    always_comb begin
        case (w_idx)
            REG_SENS_REF:    prdata = {16'b0, r_cal.sens_ref};
            REG_OFF_REF:     prdata = {16'b0, r_cal.off_ref};
            REG_SENS_TEMPCO: prdata = {16'b0, r_cal.sens_tempco};
            REG_OFF_TEMPCO:  prdata = {16'b0, r_cal.off_tempco};
            REG_TEMP_REF:    prdata = {16'b0, r_cal.temp_ref};
            REG_TEMP_TEMPCO: prdata = {16'b0, r_cal.temp_tempco};
            default:         prdata = '0;
        endcase
    end

    assign o_cal = r_cal;

endmodule

[rtl/bpc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// six-stage pipeline: dT, first-order terms, second-order correction
// ----------------------------------------------------------------------------
module bpc_front
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cal                     i_cal,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [RAW_W-1:0]         o_d1,
    output logic [COMP_W-1:0]        o_sens,
    output logic [COMP_W-1:0]        o_off,
    output logic signed [OUT_W-1:0]  o_temperature
);

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    // stage 1: dT
    logic signed [24:0]      n_dt, r_dt;
    logic [RAW_W-1:0]        r_d1_1;

    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.temp_ref, 8'b0});

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_dt   <= n_dt;
            r_d1_1 <= i_raw_pressure;
        end
    end

    // stage 2: dT products
    logic signed [41:0] n_p_temp, n_p_off, n_p_sens;
    logic signed [49:0] n_dtsq;
    logic signed [41:0] r_p_temp, r_p_off, r_p_sens;
    logic [48:0]        r_dtsq;
    logic [RAW_W-1:0]   r_d1_2;

    assign n_p_temp = r_dt * $signed({1'b0, i_cal.temp_tempco});
    assign n_p_off  = r_dt * $signed({1'b0, i_cal.off_tempco});
    assign n_p_sens = r_dt * $signed({1'b0, i_cal.sens_tempco});
    assign n_dtsq   = r_dt * r_dt;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_p_temp <= n_p_temp;
            r_p_off  <= n_p_off;
            r_p_sens <= n_p_sens;
            r_dtsq   <= n_dtsq[48:0];
            r_d1_2   <= r_d1_1;
        end
    end

    // stage 3: first-order temperature, offset, sensitivity; both T2 candidates
    logic signed [18:0] n_temp, r_temp3;
    logic [COMP_W-1:0]  n_off1, n_sens1, r_off1_3, r_sens1_3;
    logic [50:0]        n_dtsq3, n_dtsq5;
    logic [17:0]        r_t2c;
    logic [12:0]        r_t2w;
    logic [RAW_W-1:0]   r_d1_3;

    assign n_temp  = 19'sd2000 + $signed(r_p_temp[41:23]);
    assign n_off1  = {8'b0, i_cal.off_ref, 16'b0} + {{5{r_p_off[41]}}, r_p_off[41:7]};
    assign n_sens1 = {9'b0, i_cal.sens_ref, 15'b0} + {{6{r_p_sens[41]}}, r_p_sens[41:8]};
    assign n_dtsq3 = {2'b0, r_dtsq} + {1'b0, r_dtsq, 1'b0};
    assign n_dtsq5 = {2'b0, r_dtsq} + {r_dtsq, 2'b0};

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_temp3   <= n_temp;
            r_off1_3  <= n_off1;
            r_sens1_3 <= n_sens1;
            r_t2c     <= n_dtsq3[50:33];
            r_t2w     <= n_dtsq5[50:38];
            r_d1_3    <= r_d1_2;
        end
    end

    // stage 4: branch decisions, squares of the temperature distances
    logic signed [18:0] n_tc, n_lo;
    logic signed [37:0] n_tc2, n_lo2;
    logic               n_cold, n_vcold;
    logic [17:0]        n_t2;
    logic [35:0]        r_tc2, r_lo2;
    logic               r_cold4, r_vcold4;
    logic signed [OUT_W-1:0] n_tout, r_tout4;
    logic [COMP_W-1:0]  r_off1_4, r_sens1_4;
    logic [RAW_W-1:0]   r_d1_4;

    assign n_tc    = r_temp3 - 19'sd2000;
    assign n_lo    = r_temp3 + 19'sd1500;
    assign n_tc2   = n_tc * n_tc;
    assign n_lo2   = n_lo * n_lo;
    assign n_cold  = r_temp3 < 19'sd2000;
    assign n_vcold = r_temp3 < -19'sd1500;
    assign n_t2    = n_cold ? r_t2c : {5'b0, r_t2w};
    assign n_tout  = $signed({{13{r_temp3[18]}}, r_temp3}) - $signed({14'b0, n_t2});

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_tc2     <= n_tc2[35:0];
            r_lo2     <= n_lo2[35:0];
            r_cold4   <= n_cold;
            r_vcold4  <= n_vcold;
            r_tout4   <= n_tout;
            r_off1_4  <= r_off1_3;
            r_sens1_4 <= r_sens1_3;
            r_d1_4    <= r_d1_3;
        end
    end

    // stage 5: OFF2 and SENS2
    logic [41:0]        n_tc61;
    logic [40:0]        n_tc29;
    logic [39:0]        n_lo17;
    logic [38:0]        n_lo9;
    logic [COMP_W-1:0]  n_off2, n_sens2, r_off2, r_sens2;
    logic               r_cold5;
    logic signed [OUT_W-1:0] r_tout5;
    logic [COMP_W-1:0]  r_off1_5, r_sens1_5;
    logic [RAW_W-1:0]   r_d1_5;

    assign n_tc61 = {r_tc2, 6'b0} - {4'b0, r_tc2, 2'b0} + {6'b0, r_tc2};
    assign n_tc29 = {r_tc2, 5'b0} - {4'b0, r_tc2, 1'b0} - {5'b0, r_tc2};
    assign n_lo17 = {r_lo2, 4'b0} + {4'b0, r_lo2};
    assign n_lo9  = {r_lo2, 3'b0} + {3'b0, r_lo2};

    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        if (r_cold4) begin
            n_off2  = {2'b0, n_tc61[41:4]} + (r_vcold4 ? n_lo17 : '0);
            n_sens2 = {3'b0, n_tc29[40:4]} + (r_vcold4 ? {1'b0, n_lo9} : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_off2    <= n_off2;
            r_sens2   <= n_sens2;
            r_cold5   <= r_cold4;
            r_tout5   <= r_tout4;
            r_off1_5  <= r_off1_4;
            r_sens1_5 <= r_sens1_4;
            r_d1_5    <= r_d1_4;
        end
    end

    // stage 6: final offset and sensitivity
    logic [COMP_W-1:0]  r_off6, r_sens6;
    logic signed [OUT_W-1:0] r_tout6;
    logic [RAW_W-1:0]   r_d1_6;

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r_off6  <= r_off1_5 - r_off2;
            r_sens6 <= r_sens1_5 - r_sens2;
            r_tout6 <= r_tout5;
            r_d1_6  <= r_d1_5;
        end
    end

    assign o_valid       = r_v6;
    assign o_d1          = r_d1_6;
    assign o_sens        = r_sens6;
    assign o_off         = r_off6;
    assign o_temperature = r_tout6;

    // very cold is a subset of cold
    a_vcold_in_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_vcold4 |-> r_cold4)
        else $error("very cold branch taken outside cold branch");

    // warm items carry no second-order offset or sensitivity
    a_warm_no_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && !r_cold5 |-> (r_off2 == '0) && (r_sens2 == '0))
        else $error("second-order terms nonzero on warm item");

    // a stalled beat at the exit holds its data
    a_exit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 && !i_ready |=> r_v6 && $stable(r_off6) && $stable(r_sens6))
        else $error("front exit beat changed under stall");

endmodule

[rtl/bpc_press.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_press
// three-stage pressure pipeline: split D1*SENS product, sum, offset and scale
// ----------------------------------------------------------------------------
module bpc_press
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [RAW_W-1:0]         i_d1,
    input  logic [COMP_W-1:0]        i_sens,
    input  logic [COMP_W-1:0]        i_off,
    input  logic signed [OUT_W-1:0]  i_temperature,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OUT_W-1:0]  o_temperature_centi,
    output logic signed [OUT_W-1:0]  o_pressure_centi
);

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // stage 1: partial products on low and high halves of sens
    logic [43:0]             n_pp_lo, r_pp_lo;
    logic signed [44:0]      n_pp_hi, r_pp_hi;
    logic [COMP_W-1:0]       r_off1, r_off2;
    logic signed [OUT_W-1:0] r_t1, r_t2;

    assign n_pp_lo = i_d1 * i_sens[19:0];
    assign n_pp_hi = $signed({1'b0, i_d1}) * $signed(i_sens[39:20]);

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_off1  <= i_off;
            r_t1    <= i_temperature;
        end
    end

    // stage 2: full product, exact in 64 bits
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_prod <= {r_pp_hi[43:0], 20'b0} + {20'b0, r_pp_lo};
            r_off2 <= r_off1;
            r_t2   <= r_t1;
        end
    end

    // stage 3: subtract offset, floor shift to hundredths of millibar
    logic [43:0]             n_x;
    logic signed [OUT_W-1:0] r_press, r_temp;

    assign n_x = {r_prod[63], r_prod[63:21]} - {{4{r_off2[39]}}, r_off2};

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_press <= $signed({{3{n_x[43]}}, n_x[43:15]});
            r_temp  <= r_t2;
        end
    end

    assign o_valid             = r_v3;
    assign o_temperature_centi = r_temp;
    assign o_pressure_centi    = r_press;

    // with the output register empty the whole pipe can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> o_ready)
        else $error("pipe refused a beat with empty output");

    // a stalled product stage keeps its partial products
    a_pp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_en2 |=> r_v1 && $stable(r_pp_lo) && $stable(r_pp_hi))
        else $error("partial products lost under stall");

    // a result only appears when the stage behind held one
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v3) |-> $past(r_v2))
        else $error("result appeared from an empty stage");

endmodule

[rtl/baro_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
// throughput: one beat per cycle while i_out_ready is high; every stage advances
//   on its own when the one ahead is empty or moving, so bubbles collapse and no
//   beat is lost or repeated
// reset: synchronous active-low i_rst_n clears all stage valids and sets the six
//   calibration words to zero
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// second-order barometric pressure and temperature compensation pipeline
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // apb configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // raw conversion pair in
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [RAW_W-1:0]         i_raw_pressure,
    input  logic [RAW_W-1:0]         i_raw_temperature,
    // compensated result out
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_temperature_centi,
    output logic signed [OUT_W-1:0]  o_pressure_centi
);

    // calibration words; the user must keep them stable while beats are in flight, the block does not enforce it
    t_cal w_cal;

    // handoff between the temperature stages and the pressure stages
    logic                     w_mid_valid;
    logic                     w_mid_ready;
    logic [RAW_W-1:0]         w_mid_d1;
    logic [COMP_W-1:0]        w_mid_sens;
    logic [COMP_W-1:0]        w_mid_off;
    logic signed [OUT_W-1:0]  w_mid_temp;

    bpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (w_cal)
    );

    // stages 1..6: dT, first-order terms, cold and very cold corrections,
    // final OFF and SENS plus the compensated temperature
    bpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (w_cal),
        .i_valid           (i_in_valid),
        .o_ready           (o_in_ready),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (w_mid_valid),
        .i_ready           (w_mid_ready),
        .o_d1              (w_mid_d1),
        .o_sens            (w_mid_sens),
        .o_off             (w_mid_off),
        .o_temperature     (w_mid_temp)
    );

    // stages 7..9: D1*SENS as two partial products, offset and final shift;
    // stage 9 is the output register
    bpc_press u_press (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (w_mid_valid),
        .o_ready             (w_mid_ready),
        .i_d1                (w_mid_d1),
        .i_sens              (w_mid_sens),
        .i_off               (w_mid_off),
        .i_temperature       (w_mid_temp),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_centi    (o_pressure_centi)
    );

endmodule

[tb/baro_pressure_temp_compensation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_tb
// self-checking bench: programs calibration words over apb, streams raw
// pressure/temperature pairs with random gaps and output stalls, and checks
// every compensated result against an in-bench 64-bit integer predictor
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_tb
    import bpc_pkg::*;
();

    localparam int N_CAL         = 6;
    localparam int SETTLE_CYCLES = 12;    // pipeline is 9 deep, plus margin
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake of any kind
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_PAIRS   = 275;
    localparam int STREAM_PAIRS  = 300;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

    // register map, one word every 4 bytes; the two spares lie past the last register
    typedef enum logic [2:0] {
        CAL_SENS_REF, CAL_OFF_REF, CAL_SENS_TEMPCO, CAL_OFF_TEMPCO,
        CAL_TEMP_REF, CAL_TEMP_TEMPCO, CAL_SPARE_A, CAL_SPARE_B
    } t_cal_idx;

    typedef enum logic [1:0] {BR_WARM, BR_COLD, BR_VERY_COLD} t_branch;

    typedef struct {
        logic signed [OUT_W-1:0] temperature;
        logic signed [OUT_W-1:0] pressure;
    } t_reading;

    // block ports
    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [4:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [RAW_W-1:0]         i_raw_pressure = '0;
    logic [RAW_W-1:0]         i_raw_temperature = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b1;
    logic signed [OUT_W-1:0]  o_temperature_centi;
    logic signed [OUT_W-1:0]  o_pressure_centi;

    // bench copy of the calibration and the readings still owed by the block
    t_cal      cal_shadow = '0;
    t_reading  pending_readings[$];

    // a typical factory calibration, used as the center of random sets
    logic [CAL_W-1:0] typical_cal [N_CAL] = '{16'd40127, 16'd36924, 16'd23317,
                                              16'd23282, 16'd33464, 16'd28312};

    bit in_gaps_on   = 1'b0;
    bit out_stalls_on = 1'b0;
    int error_count  = 0;
    int pair_count   = 0;
    int cal_sets     = 0;
    int branch_hits [3] = '{0, 0, 0};
    int stall_cycles = 0;

    baro_pressure_temp_compensation i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_centi    (o_pressure_centi)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor: second-order compensation in exact 64-bit signed arithmetic;
    // >>> on signed longint rounds toward minus infinity
    // ------------------------------------------------------------------------
    function automatic void compensate_pair(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw,
                                            output t_reading r,
                                            output t_branch br);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, t2, off2, sens2, off, sens, p, tc, lo;
        d1 = longint'(d1_raw);
        d2 = longint'(d2_raw);
        c1 = longint'(cal_shadow.sens_ref);
        c2 = longint'(cal_shadow.off_ref);
        c3 = longint'(cal_shadow.sens_tempco);
        c4 = longint'(cal_shadow.off_tempco);
        c5 = longint'(cal_shadow.temp_ref);
        c6 = longint'(cal_shadow.temp_tempco);

        dt   = d2 - c5 * 256;
        temp = 2000 + ((dt * c6) >>> 23);

        if (temp < 2000) begin
            // cold: quadratic terms in the distance below 20.00 degC
            tc    = temp - 2000;
            t2    = (3 * dt * dt) >>> 33;
            off2  = (61 * tc * tc) >>> 4;
            sens2 = (29 * tc * tc) >>> 4;
            br    = BR_COLD;
            if (temp < -1500) begin
                // very cold: extra terms below -15.00 degC
                lo    = temp + 1500;
                off2  = off2 + 17 * lo * lo;
                sens2 = sens2 + 9 * lo * lo;
                br    = BR_VERY_COLD;
            end
        end else begin
            t2    = (5 * dt * dt) >>> 38;
            off2  = 0;
            sens2 = 0;
            br    = BR_WARM;
        end

        off  = c2 * 65536 + ((c4 * dt) >>> 7) - off2;
        sens = c1 * 32768 + ((c3 * dt) >>> 8) - sens2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;

        // both results keep their low 32 bits, two's complement
        r.temperature = 32'(temp - t2);
        r.pressure    = 32'(p);
    endfunction

    // smallest dt whose first-order temperature reaches target
    function automatic longint dt_for_temp(input longint target);
        longint num, c6;
        c6  = longint'(cal_shadow.temp_tempco);
        num = (target - 2000) * 8388608;
        if (c6 == 0)
            return 0;
        if (num >= 0)
            return (num + c6 - 1) / c6;
        return -((-num) / c6);
    endfunction

    // raw temperature word that lands nudge counts from the target threshold
    function automatic logic [RAW_W-1:0] raw_temp_at(input longint target,
                                                     input longint nudge);
        longint v, c5;
        c5 = longint'(cal_shadow.temp_ref);
        v  = c5 * 256 + dt_for_temp(target) + nudge;
        if (v < 0)
            v = 0;
        if (v > longint'(RAW_MAX))
            v = longint'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [CAL_W-1:0] cal_word(input t_cal_idx idx);
        case (idx)
            CAL_SENS_REF:    return cal_shadow.sens_ref;
            CAL_OFF_REF:     return cal_shadow.off_ref;
            CAL_SENS_TEMPCO: return cal_shadow.sens_tempco;
            CAL_OFF_TEMPCO:  return cal_shadow.off_tempco;
            CAL_TEMP_REF:    return cal_shadow.temp_ref;
            CAL_TEMP_TEMPCO: return cal_shadow.temp_tempco;
            default:         return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // apb access; each call starts right after a rising edge and leaves the cycle
    // after the access idle so back-to-back calls never collide
    // ------------------------------------------------------------------------
    task automatic write_cal_word(input t_cal_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // upper data bits are dropped; spare addresses hold nothing
        case (idx)
            CAL_SENS_REF:    cal_shadow.sens_ref    = data[CAL_W-1:0];
            CAL_OFF_REF:     cal_shadow.off_ref     = data[CAL_W-1:0];
            CAL_SENS_TEMPCO: cal_shadow.sens_tempco = data[CAL_W-1:0];
            CAL_OFF_TEMPCO:  cal_shadow.off_tempco  = data[CAL_W-1:0];
            CAL_TEMP_REF:    cal_shadow.temp_ref    = data[CAL_W-1:0];
            CAL_TEMP_TEMPCO: cal_shadow.temp_tempco = data[CAL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic read_cal_word(input t_cal_idx idx);
        logic [31:0] want;
        want    = {16'b0, cal_word(idx)};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t readback of %s: expected %h actual %h",
                     $time, idx.name(), want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // writes all six words with junk in the upper half, then reads them back
    task automatic program_calibration(input logic [CAL_W-1:0] words [N_CAL]);
        for (int i = 0; i < N_CAL; i++)
            write_cal_word(t_cal_idx'(i), {16'($urandom), words[i]});
        for (int i = 0; i < N_CAL; i++)
            read_cal_word(t_cal_idx'(i));
        cal_sets++;
    endtask

    // ------------------------------------------------------------------------
    // input beats: valid stays high between back-to-back pairs and only drops
    // for a gap or in settle_pipeline
    // ------------------------------------------------------------------------
    task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        t_reading r;
        t_branch  br;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= d1;
        i_raw_temperature <= d2;
        // calibration is frozen while pairs are in flight, so predict now
        compensate_pair(d1, d2, r, br);
        pending_readings.push_back(r);
        branch_hits[br]++;
        pair_count++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop valid, wait out every owed reading, then let the pipe go quiet
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side back-pressure in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_stalls_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // result checker: every output beat is compared with the oldest prediction
    always @(posedge i_clk) begin : check_readings
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t unexpected output beat: temperature %0d pressure %0d",
                         $time, o_temperature_centi, o_pressure_centi);
                error_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_centi !== want.temperature) begin
                    $display("%0t temperature_centi: expected %0d actual %0d",
                             $time, want.temperature, o_temperature_centi);
                    error_count++;
                end
                if (o_pressure_centi !== want.pressure) begin
                    $display("%0t pressure_centi: expected %0d actual %0d",
                             $time, want.pressure, o_pressure_centi);
                    error_count++;
                end
            end
        end
    end

    // watchdog: any beat on either channel or an apb access counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no progress for %0d cycles, %0d readings owed",
                     $time, STALL_LIMIT, pending_readings.size());
            $display("[baro_pressure_temp_compensation] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // all calibration words are zero out of reset
    task automatic test_reset_calibration();
        for (int i = 0; i < N_CAL; i++)
            read_cal_word(t_cal_idx'(i));
        send_pair('0, '0);
        send_pair(RAW_MAX, '0);
        send_pair('0, RAW_MAX);
        send_pair(RAW_MAX, RAW_MAX);
        settle_pipeline();
    endtask

    // write/readback of every word, writes to spare addresses change nothing
    task automatic test_register_access();
        program_calibration(typical_cal);
        write_cal_word(CAL_SPARE_A, $urandom);
        write_cal_word(CAL_SPARE_B, $urandom);
        for (int i = 0; i < N_CAL; i++)
            read_cal_word(t_cal_idx'(i));
    endtask

    // warm, cold and very cold branches right at their thresholds
    task automatic test_temperature_branches();
        send_pair(24'd9085466, raw_temp_at(2000, 0));    // exactly 20.00: warm
        send_pair(24'd9085466, raw_temp_at(2000, -1));   // 19.99: cold
        send_pair(RAW_MAX,     raw_temp_at(-1500, 0));   // -15.00: cold only
        send_pair('0,          raw_temp_at(-1500, -1));  // -15.01: very cold
        send_pair(RAW_MAX,     raw_temp_at(-1500, -1));
        send_pair('0,          '0);
        send_pair(RAW_MAX,     '0);
        send_pair('0,          RAW_MAX);
        send_pair(RAW_MAX,     RAW_MAX);
        send_pair(24'h800000,  24'h800000);
        settle_pipeline();
    endtask

    // every calibration word at its maximum, then a mixed corner set
    task automatic test_calibration_extremes();
        logic [CAL_W-1:0] words [N_CAL];
        foreach (words[i])
            words[i] = '1;
        program_calibration(words);
        send_pair('0,      '0);      // deepest very cold point
        send_pair(RAW_MAX, '0);
        send_pair('0,      RAW_MAX);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, raw_temp_at(-1500, -1));
        settle_pipeline();
        words = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
        program_calibration(words);
        send_pair(RAW_MAX, '0);
        send_pair(RAW_MAX, RAW_MAX);
        settle_pipeline();
    endtask

    function automatic logic [CAL_W-1:0] pick_cal_word(input int i);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 16'($urandom);
            default: return 16'(typical_cal[i] + $urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    task automatic send_random_pairs(input int count);
        logic [RAW_W-1:0] d1, d2;
        longint           target;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0:       d1 = '0;
                1:       d1 = RAW_MAX;
                default: d1 = 24'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       d2 = ($urandom_range(0, 1) != 0) ? RAW_MAX : '0;
                1, 2, 3: d2 = 24'($urandom);
                4: begin
                    // at or well below the very cold threshold
                    target = -1500 - longint'($urandom_range(0, 150000));
                    d2 = raw_temp_at(target, 0);
                end
                default: begin
                    // spread around the two branch thresholds
                    target = longint'($urandom_range(0, 13000)) - 5000;
                    d2 = raw_temp_at(target, longint'($urandom_range(0, 2)) - 1);
                end
            endcase
            send_pair(d1, d2);
        end
    endtask

    // random calibration sets, idling on both sides except for one phase
    task automatic test_random_mix();
        logic [CAL_W-1:0] words [N_CAL];
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            foreach (words[i])
                words[i] = pick_cal_word(i);
            program_calibration(words);
            in_gaps_on    = (ph != 2);
            out_stalls_on = (ph != 2);
            send_random_pairs(PHASE_PAIRS);
            settle_pipeline();
        end
    endtask

    // closing stretch at full rate with no gaps and no stalls
    task automatic test_streaming();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        program_calibration(typical_cal);
        send_random_pairs(STREAM_PAIRS);
        settle_pipeline();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_register_access();
        test_temperature_branches();
        test_calibration_extremes();
        test_random_mix();
        test_streaming();

        $display("checked %0d reading pairs over %0d calibration sets",
                 pair_count, cal_sets);
        $display("branches hit: warm %0d, cold %0d, very cold %0d",
                 branch_hits[BR_WARM], branch_hits[BR_COLD], branch_hits[BR_VERY_COLD]);
        if (error_count == 0)
            $display("[baro_pressure_temp_compensation] OK");
        else
            $display("[baro_pressure_temp_compensation] ERROR");
        $finish;
    end

endmodule

[baro_pressure_temp_compensation.f]
rtl/bpc_pkg.sv
rtl/bpc_apb_regs.sv
rtl/bpc_front.sv
rtl/bpc_press.sv
rtl/baro_pressure_temp_compensation.sv
tb/baro_pressure_temp_compensation_tb.sv
